### hdl/hrf_pkg.sv
`timescale 1ns / 1ps
package hrf_pkg;

    localparam int VALUE_BITS_DEF        = 63;
    localparam int HEADER_COUNT_BITS_DEF = 21;
    localparam int CFG_WIDTH             = 21;
    localparam int CFG_ADDR_BITS         = 3;
    localparam int QUEUE_DEPTH           = 4;

    localparam logic [CFG_WIDTH-1:0]     MAX_HDR_RESET = 21'd1048576;
    localparam logic [CFG_ADDR_BITS-1:0] ADDR_MAX_HDR  = 3'd0;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_C     = 8'h63;

    typedef enum logic [1:0] {
        KIND_HEADERS = 2'd0,
        KIND_BODY    = 2'd1,
        KIND_TOOLONG = 2'd2
    } kind_t;

    typedef enum logic {
        PH_HEADER = 1'b0,
        PH_BODY   = 1'b1
    } phase_t;

    typedef enum logic [2:0] {
        TL_NONE    = 3'd0,
        TL_CR      = 3'd1,
        TL_LF      = 3'd2,
        TL_CRLF    = 3'd3,
        TL_CRLFCR  = 3'd4
    } tail_t;

    typedef enum logic [2:0] {
        LP_START  = 3'd0,
        LP_NAME   = 3'd1,
        LP_SKIP   = 3'd2,
        LP_WS     = 3'd3,
        LP_SIGN   = 3'd4,
        LP_DIGITS = 3'd5,
        LP_SCAN   = 3'd6
    } line_phase_t;

    typedef enum logic [1:0] {
        TG_NONE = 2'd0,
        TG_LEN  = 2'd1,
        TG_TIME = 2'd2,
        TG_CONN = 2'd3
    } target_t;

    function automatic logic [4:0] name_size(input logic [1:0] idx);
        logic [4:0] n;
        case (idx)
            2'd0:    n = 5'd15;
            2'd1:    n = 5'd14;
            2'd2:    n = 5'd11;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [8*15-1:0] s;
        logic [7:0]      ch;
        case (idx)
            2'd0:    s = "content-length:";
            2'd1:    s = {"x-bench-t0-ns:", 8'h00};
            2'd2:    s = {"connection:", 32'h0};
            default: s = '0;
        endcase
        if (pos == 4'd15)
        begin
            ch = 8'h00;
        end
        else
        begin
            ch = s[8*(14 - 32'(pos)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "c";
            3'd1:    ch = "l";
            3'd2:    ch = "o";
            3'd3:    ch = "s";
            3'd4:    ch = "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hdl/hrf_if.sv
`timescale 1ns / 1ps
interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrf_out_if #(
    parameter int VALUE_BITS        = 63,
    parameter int HEADER_COUNT_BITS = 21
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [HEADER_COUNT_BITS-1:0] header_length;
    logic [VALUE_BITS-1:0]        req_length;
    logic [VALUE_BITS-1:0]        start_time;
    logic                         start_time_valid;
    logic                         close_requested;
    logic [VALUE_BITS-1:0]        body_bytes;
    logic                         last;

    modport source (output valid, output kind, output header_length, output req_length,
                    output start_time, output start_time_valid, output close_requested,
                    output body_bytes, output last, input ready);
    modport sink   (input valid, input kind, input header_length, input req_length,
                    input start_time, input start_time_valid, input close_requested,
                    input body_bytes, input last, output ready);
endinterface

### hdl/http_request_framer_core.sv
`timescale 1ns / 1ps
// HTTP/1.1 request header framer.
// data_in carries one request-stream byte per word; result_out carries one
// result per word: headers complete, body complete, or header too long.
// An APB port holds max_header_bytes at address 0 (reset 1048576).
// Throughput: one byte per cycle while data_in.ready is high. A byte that ends
// a header with a zero body length yields two results, which drain one per
// cycle while result_out.ready is high. The parser writes a byte's results
// into the queue at the edge that accepts the byte; the output register then
// loads them from the queue whenever it is empty or its word is taken.
// The parser sits in front of a four-entry result queue; data_in.ready drops
// while fewer than two entries are free.
// When result_out stalls, the output register holds its word and the queue
// absorbs new results; input is held off once fewer than two entries are free.
// Reset clears the parser, the queue and the output register, and restores
// the header limit; the block takes bytes right after reset.
module http_request_framer_core
    import hrf_pkg::*;
#(
    parameter int VALUE_BITS        = VALUE_BITS_DEF,
    parameter int HEADER_COUNT_BITS = HEADER_COUNT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    hrf_in_if.sink                   data_in,
    hrf_out_if.source                result_out,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int VB    = VALUE_BITS;
    localparam int HCB   = HEADER_COUNT_BITS;
    localparam int RES_W = 2 + HCB + 3 * VB + 3;
    localparam logic [32:0] CAP = (33'(1) << HCB) - 33'd5;

    logic [CFG_WIDTH-1:0] maxhdr_reg;
    logic [HCB-1:0]       limit;
    logic [1:0]           push_cnt;
    logic [RES_W-1:0]     push_a;
    logic [RES_W-1:0]     push_b;
    logic                 room2;
    logic                 q_nonempty;
    logic [RES_W-1:0]     q_head;
    logic                 q_pop;
    logic [RES_W-1:0]     out_data;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_HDR) ? 32'(maxhdr_reg) : 32'd0;
    assign limit  = (33'(maxhdr_reg) < CAP) ? HCB'(maxhdr_reg) : CAP[HCB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxhdr_reg <= MAX_HDR_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_MAX_HDR)
        begin
            maxhdr_reg <= pwdata[CFG_WIDTH-1:0];
        end
    end

    assign data_in.ready = room2;

    hrf_front #(
        .VALUE_BITS        (VB),
        .HEADER_COUNT_BITS (HCB),
        .RES_W             (RES_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (data_in.valid),
        .in_byte  (data_in.data_byte),
        .in_ready (room2),
        .limit    (limit),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b)
    );

    hrf_queue #(
        .W (RES_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (push_a),
        .push_b   (push_b),
        .room2    (room2),
        .nonempty (q_nonempty),
        .head     (q_head),
        .pop      (q_pop)
    );

    hrf_back #(
        .W (RES_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (result_out.valid),
        .out_data   (out_data),
        .out_ready  (result_out.ready)
    );

    assign {result_out.kind, result_out.header_length, result_out.req_length,
            result_out.start_time, result_out.start_time_valid, result_out.close_requested,
            result_out.body_bytes, result_out.last} = out_data;

endmodule

### hdl/hrf_front.sv
`timescale 1ns / 1ps
module hrf_front
    import hrf_pkg::*;
#(
    parameter int VALUE_BITS        = VALUE_BITS_DEF,
    parameter int HEADER_COUNT_BITS = HEADER_COUNT_BITS_DEF,
    parameter int RES_W             = 2 + HEADER_COUNT_BITS + 3 * VALUE_BITS + 3
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [7:0]                   in_byte,
    input  logic                         in_ready,
    input  logic [HEADER_COUNT_BITS-1:0] limit,
    output logic [1:0]                   push_cnt,
    output logic [RES_W-1:0]             push_a,
    output logic [RES_W-1:0]             push_b
);

    localparam int VB  = VALUE_BITS;
    localparam int HCB = HEADER_COUNT_BITS;

    phase_t              phase_reg,  phase_next;
    tail_t               tail_reg,   tail_next,   tail_upd;
    logic [HCB-1:0]      hcount_reg, hcount_next, hcount_upd;
    line_phase_t         lphase_reg, lphase_next, lphase_upd;
    logic [3:0]          npos_reg,   npos_next,   npos_upd;
    logic [2:0]          cands_reg,  cands_next,  cands_upd;
    target_t             target_reg, target_next, target_upd;
    logic [2:0]          tpos_reg,   tpos_next,   tpos_upd;
    logic [VB:0]         accum_reg,  accum_next,  accum_upd;
    logic                neg_reg,    neg_next,    neg_upd;
    logic                lfound_reg, lfound_next, lfound_upd;
    logic [VB-1:0]       lval_reg,   lval_next,   lval_upd;
    logic                tfound_reg, tfound_next, tfound_upd;
    logic [VB-1:0]       tval_reg,   tval_next,   tval_upd;
    logic                close_reg,  close_next,  close_upd;
    logic [VB-1:0]       remain_reg, remain_next;

    logic                take;
    logic [7:0]          lc;
    logic                is_digit;
    logic [VB+4:0]       acc10;
    logic [VB+4:0]       acc_lim;
    logic                add_ovf;
    logic                term_hit;
    logic                too_long;
    logic                body_done;
    logic                do_clear;
    logic [1:0]          tp;
    logic [VB-1:0]       remain_dec;

    assign take     = in_valid && in_ready;
    assign lc       = (in_byte >= CH_UA && in_byte <= CH_UZ) ? in_byte + 8'd32 : in_byte;
    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign acc10    = (VB+5)'({accum_reg, 3'b000}) + (VB+5)'({accum_reg, 1'b0})
                    + (VB+5)'(in_byte - CH_ZERO);
    assign acc_lim  = ((VB+5)'(1) << VB) - (VB+5)'(!neg_reg);
    assign add_ovf  = acc10 > acc_lim;
    assign remain_dec = (remain_reg != '0) ? remain_reg - VB'(1) : remain_reg;

    always_comb
    begin
        line_phase_t lp;
        logic [3:0]  pn;
        tail_upd   = tail_reg;
        hcount_upd = hcount_reg;
        lphase_upd = lphase_reg;
        npos_upd   = npos_reg;
        cands_upd  = cands_reg;
        target_upd = target_reg;
        tpos_upd   = tpos_reg;
        accum_upd  = accum_reg;
        neg_upd    = neg_reg;
        lfound_upd = lfound_reg;
        lval_upd   = lval_reg;
        tfound_upd = tfound_reg;
        tval_upd   = tval_reg;
        close_upd  = close_reg;
        term_hit   = 1'b0;
        too_long   = 1'b0;
        body_done  = 1'b0;
        tp         = 2'd0;
        lp         = lphase_reg;
        pn         = npos_reg + 4'd1;
        remain_next = remain_reg;
        phase_next  = phase_reg;

        if (take && phase_reg == PH_BODY)
        begin
            remain_next = remain_dec;
            if (remain_dec == '0)
            begin
                body_done  = 1'b1;
                phase_next = PH_HEADER;
            end
        end
        else if (take)
        begin
            hcount_upd = hcount_reg + HCB'(1);
            if (in_byte == CH_LF)
            begin
                if (lphase_reg == LP_DIGITS)
                begin
                    if (target_reg == TG_LEN && !lfound_reg)
                    begin
                        lfound_upd = 1'b1;
                        lval_upd   = neg_reg ? '0 : accum_reg[VB-1:0];
                    end
                    else if (target_reg == TG_TIME && !tfound_reg)
                    begin
                        tfound_upd = 1'b1;
                        tval_upd   = (!neg_reg && accum_reg != '0) ? accum_reg[VB-1:0] : '0;
                    end
                end
                lphase_upd = LP_START;
            end
            else if (!(lphase_reg == LP_START && in_byte == CH_CR))
            begin
                if (lphase_reg == LP_START)
                begin
                    cands_upd  = 3'b111;
                    target_upd = TG_NONE;
                    lp         = LP_NAME;
                    pn         = 4'd1;
                end
                case (lp)
                    LP_NAME:
                    begin
                        if (lphase_reg == LP_START)
                        begin
                            cands_upd = 3'b111;
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            if (cands_upd[i] &&
                                ((5'(pn - 4'd1) >= name_size(2'(i))) ||
                                 (name_char(2'(i), pn - 4'd1) != lc)))
                            begin
                                cands_upd[i] = 1'b0;
                            end
                        end
                        npos_upd = pn;
                        if (cands_upd == 3'b000)
                        begin
                            lphase_upd = LP_SKIP;
                        end
                        else
                        begin
                            lphase_upd = LP_NAME;
                            for (int i = 0; i < 3; i++)
                            begin
                                if (cands_upd[i] && name_size(2'(i)) == 5'(pn))
                                begin
                                    target_upd = target_t'(2'(i + 1));
                                    accum_upd  = '0;
                                    neg_upd    = 1'b0;
                                    tpos_upd   = 3'd0;
                                    lphase_upd = (i == 2) ? LP_SCAN : LP_WS;
                                end
                            end
                        end
                    end
                    LP_WS:
                    begin
                        if (in_byte == CH_SP || in_byte == CH_TAB || in_byte == CH_VT ||
                            in_byte == CH_FF || in_byte == CH_CR)
                        begin
                            lphase_upd = LP_WS;
                        end
                        else if (in_byte == CH_PLUS || in_byte == CH_MINUS)
                        begin
                            neg_upd    = (in_byte == CH_MINUS);
                            lphase_upd = LP_SIGN;
                        end
                        else if (is_digit)
                        begin
                            lphase_upd = add_ovf ? LP_SKIP : LP_DIGITS;
                            accum_upd  = add_ovf ? accum_reg : acc10[VB:0];
                        end
                        else
                        begin
                            lphase_upd = LP_SKIP;
                        end
                    end
                    LP_SIGN, LP_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            lphase_upd = add_ovf ? LP_SKIP : LP_DIGITS;
                            accum_upd  = add_ovf ? accum_reg : acc10[VB:0];
                        end
                        else
                        begin
                            lphase_upd = LP_SKIP;
                            if (lp == LP_DIGITS && target_reg == TG_LEN && !lfound_reg)
                            begin
                                lfound_upd = 1'b1;
                                lval_upd   = neg_reg ? '0 : accum_reg[VB-1:0];
                            end
                            else if (lp == LP_DIGITS && target_reg == TG_TIME && !tfound_reg)
                            begin
                                tfound_upd = 1'b1;
                                tval_upd   = (!neg_reg && accum_reg != '0) ?
                                             accum_reg[VB-1:0] : '0;
                            end
                        end
                    end
                    LP_SCAN:
                    begin
                        if (lc == close_char(tpos_reg))
                        begin
                            if (tpos_reg >= 3'd4)
                            begin
                                close_upd = 1'b1;
                                tpos_upd  = 3'd0;
                            end
                            else
                            begin
                                tpos_upd = tpos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            tpos_upd = (lc == CH_C) ? 3'd1 : 3'd0;
                        end
                    end
                    default:
                    begin
                        lphase_upd = lp;
                    end
                endcase
            end

            if (in_byte == CH_LF)
            begin
                if (tail_reg == TL_LF || tail_reg == TL_CRLF || tail_reg == TL_CRLFCR)
                begin
                    tail_upd = TL_NONE;
                    term_hit = 1'b1;
                end
                else
                begin
                    tail_upd = (tail_reg == TL_CR) ? TL_CRLF : TL_LF;
                end
            end
            else if (in_byte == CH_CR)
            begin
                tail_upd = (tail_reg == TL_CRLF) ? TL_CRLFCR : TL_CR;
            end
            else
            begin
                tail_upd = TL_NONE;
            end

            case (tail_upd)
                TL_CR, TL_LF: tp = 2'd1;
                TL_CRLF:      tp = 2'd2;
                TL_CRLFCR:    tp = 2'd3;
                default:      tp = 2'd0;
            endcase

            if (term_hit)
            begin
                if (lval_upd != '0)
                begin
                    phase_next  = PH_BODY;
                    remain_next = lval_upd;
                end
            end
            else if ((hcount_upd - HCB'(tp)) > limit)
            begin
                too_long = 1'b1;
            end
        end

        do_clear = body_done || too_long || (term_hit && lval_upd == '0);

        tail_next   = do_clear ? TL_NONE  : tail_upd;
        hcount_next = do_clear ? '0       : hcount_upd;
        lphase_next = do_clear ? LP_START : lphase_upd;
        npos_next   = do_clear ? 4'd0     : npos_upd;
        cands_next  = do_clear ? 3'd0     : cands_upd;
        target_next = do_clear ? TG_NONE  : target_upd;
        tpos_next   = do_clear ? 3'd0     : tpos_upd;
        accum_next  = do_clear ? '0       : accum_upd;
        neg_next    = do_clear ? 1'b0     : neg_upd;
        lfound_next = do_clear ? 1'b0     : lfound_upd;
        lval_next   = do_clear ? '0       : lval_upd;
        tfound_next = do_clear ? 1'b0     : tfound_upd;
        tval_next   = do_clear ? '0       : tval_upd;
        close_next  = do_clear ? 1'b0     : close_upd;
        if (do_clear)
        begin
            remain_next = '0;
        end
    end

    always_comb
    begin
        logic [VB-1:0] tv;
        tv       = (tval_upd != '0) ? tval_upd : '0;
        push_cnt = 2'd0;
        push_a   = '0;
        push_b   = '0;
        if (body_done)
        begin
            push_cnt = 2'd1;
            push_a   = {KIND_BODY, hcount_reg, lval_reg, tval_reg, (tval_reg != '0),
                        close_reg, lval_reg, 1'b1};
        end
        else if (term_hit)
        begin
            push_a = {KIND_HEADERS, hcount_upd, lval_upd, tv, (tval_upd != '0),
                      close_upd, {VB{1'b0}}, (lval_upd != '0)};
            push_b = {KIND_BODY, hcount_upd, lval_upd, tv, (tval_upd != '0),
                      close_upd, {VB{1'b0}}, 1'b1};
            push_cnt = (lval_upd == '0) ? 2'd2 : 2'd1;
        end
        else if (too_long)
        begin
            push_cnt = 2'd1;
            push_a   = {KIND_TOOLONG, hcount_upd, {VB{1'b0}}, {VB{1'b0}}, 1'b0,
                        1'b0, {VB{1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            tail_reg   <= TL_NONE;
            hcount_reg <= '0;
            lphase_reg <= LP_START;
            npos_reg   <= '0;
            cands_reg  <= '0;
            target_reg <= TG_NONE;
            tpos_reg   <= '0;
            accum_reg  <= '0;
            neg_reg    <= 1'b0;
            lfound_reg <= 1'b0;
            lval_reg   <= '0;
            tfound_reg <= 1'b0;
            tval_reg   <= '0;
            close_reg  <= 1'b0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tail_reg   <= tail_next;
            hcount_reg <= hcount_next;
            lphase_reg <= lphase_next;
            npos_reg   <= npos_next;
            cands_reg  <= cands_next;
            target_reg <= target_next;
            tpos_reg   <= tpos_next;
            accum_reg  <= accum_next;
            neg_reg    <= neg_next;
            lfound_reg <= lfound_next;
            lval_reg   <= lval_next;
            tfound_reg <= tfound_next;
            tval_reg   <= tval_next;
            close_reg  <= close_next;
            remain_reg <= remain_next;
        end
    end

endmodule

### hdl/hrf_queue.sv
`timescale 1ns / 1ps
module hrf_queue
    import hrf_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   push_cnt,
    input  logic [W-1:0] push_a,
    input  logic [W-1:0] push_b,
    output logic         room2,
    output logic         nonempty,
    output logic [W-1:0] head,
    input  logic         pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [W-1:0]  mem [QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [PW:0]   cnt_reg,  cnt_next;

    assign room2    = cnt_reg <= (PW+1)'(QUEUE_DEPTH - 2);
    assign nonempty = cnt_reg != '0;
    assign head     = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg + PW'(push_cnt);
        rptr_next = rptr_reg + PW'(pop);
        cnt_next  = cnt_reg + (PW+1)'(push_cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wptr_reg + PW'(1)] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

### hdl/hrf_back.sv
`timescale 1ns / 1ps
module hrf_back
    import hrf_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_nonempty,
    input  logic [W-1:0] q_head,
    output logic         q_pop,
    output logic         out_valid,
    output logic [W-1:0] out_data,
    input  logic         out_ready
);

    logic         valid_reg, valid_next;
    logic [W-1:0] data_reg;

    assign q_pop     = q_nonempty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = q_pop || (valid_reg && !out_ready);
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

### hdl/hrf_checker.sv
`timescale 1ns / 1ps
module hrf_checker
    import hrf_pkg::*;
#(
    parameter int VALUE_BITS        = VALUE_BITS_DEF,
    parameter int HEADER_COUNT_BITS = HEADER_COUNT_BITS_DEF
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            kind,
    input logic [VALUE_BITS-1:0] req_length,
    input logic [VALUE_BITS-1:0] start_time,
    input logic                  start_time_valid,
    input logic [VALUE_BITS-1:0] body_bytes,
    input logic                  last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(body_bytes))
        else $error("result word changed while stalled");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind != 2'd3)
        else $error("undefined result kind");

    a_toolong: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_TOOLONG |->
            last && req_length == '0 && start_time == '0 && !start_time_valid)
        else $error("header-too-long result carries values");

    a_stv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_time_valid == (start_time != '0))
        else $error("start_time_valid disagrees with start_time");

    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_HEADERS |-> body_bytes == '0 &&
            last == (req_length != '0))
        else $error("headers-complete result inconsistent");

endmodule

bind http_request_framer_core hrf_checker #(
    .VALUE_BITS        (VALUE_BITS),
    .HEADER_COUNT_BITS (HEADER_COUNT_BITS)
) u_hrf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .out_valid        (result_out.valid),
    .out_ready        (result_out.ready),
    .kind             (result_out.kind),
    .req_length       (result_out.req_length),
    .start_time       (result_out.start_time),
    .start_time_valid (result_out.start_time_valid),
    .body_bytes       (result_out.body_bytes),
    .last             (result_out.last)
);
